// ===== hdl/metsub_pkg.sv =====
// ============================================================================
// metsub_pkg - shared constants and helpers for the subdivision level block
// Holds the tick resolution, derived widths and the trailing-zero count.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package metsub_pkg;

	// Tick resolution of one quarter note.
	localparam int TICKS_PER_QUARTER = 480;
	// Length of a whole note in ticks; the denominator unit is this over the denominator.
	localparam int WHOLE_TICKS       = 4 * TICKS_PER_QUARTER;

	localparam int TICK_W  = 24;
	localparam int DEN_W   = 7;
	localparam int LEVEL_W = 5;
	localparam int MAXL_W  = 4;
	localparam int UNIT_W  = $clog2(WHOLE_TICKS + 1);
	localparam int DVS_W   = (UNIT_W > DEN_W) ? UNIT_W : DEN_W;
	localparam int LVL_W   = $clog2(UNIT_W + 2);
	localparam int CNT_W   = $clog2(TICK_W);

	localparam int LEVEL_MAX = 15;
	localparam int LEVEL_NEG = 16;
	localparam int MAXL_MAX  = 15;

	// Configuration register indexes and reset values.
	localparam logic REG_METER_DEN = 1'b0;
	localparam logic [DEN_W-1:0] METER_DEN_RESET = DEN_W'(4);

	// Number of exact halvings of a nonzero unit length, saturated.
	function automatic logic [MAXL_W-1:0] trailing_zeros(input logic [UNIT_W-1:0] u);
		logic [LVL_W-1:0] n;
		n = '0;
		for (int i = UNIT_W - 1; i >= 0; i--) begin
			if (u[i]) begin
				n = LVL_W'(i);
			end
		end
		if (32'(n) > MAXL_MAX) begin
			return MAXL_W'(MAXL_MAX);
		end
		return MAXL_W'(n);
	endfunction

endpackage

`default_nettype wire

// ===== hdl/metsub_div.sv =====
// ============================================================================
// metsub_div - shared restoring divider
// Produces quotient and remainder of a tick-wide dividend, one bit per cycle.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module metsub_div (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             go,
	input  wire logic [metsub_pkg::TICK_W-1:0]    dividend,
	input  wire logic [metsub_pkg::DVS_W-1:0]     divisor,
	output logic                                  done,
	output logic [metsub_pkg::TICK_W-1:0]         quotient,
	output logic [metsub_pkg::DVS_W-1:0]          remainder
);

	logic                            run_q;
	logic                            done_q;
	logic [metsub_pkg::CNT_W-1:0]    cnt_q;
	logic [metsub_pkg::TICK_W-1:0]   quo_q;
	logic [metsub_pkg::DVS_W-1:0]    rem_q;
	logic [metsub_pkg::DVS_W-1:0]    dvs_q;
	logic [metsub_pkg::DVS_W:0]      trial;
	logic [metsub_pkg::DVS_W:0]      diff;
	logic                            fits;

	// One restoring step: bring down the next dividend bit and try the subtract.
	always_comb begin
		trial = {rem_q, quo_q[metsub_pkg::TICK_W-1]};
		diff  = trial - {1'b0, dvs_q};
		fits  = (trial >= {1'b0, dvs_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			quo_q  <= '0;
			rem_q  <= '0;
			dvs_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				quo_q <= dividend;
				rem_q <= '0;
				dvs_q <= divisor;
				cnt_q <= metsub_pkg::CNT_W'(metsub_pkg::TICK_W - 1);
			end else if (run_q) begin
				quo_q <= {quo_q[metsub_pkg::TICK_W-2:0], fits};
				rem_q <= fits ? diff[metsub_pkg::DVS_W-1:0] : trial[metsub_pkg::DVS_W-1:0];
				if (cnt_q == '0) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

`default_nettype wire

// ===== hdl/metsub_halve.sv =====
// ============================================================================
// metsub_halve - quotient and remainder update when the unit is halved
// For an even unit u, t / (u/2) = 2q + (r >= u/2) and the remainder folds down.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module metsub_halve (
	input  wire logic [metsub_pkg::TICK_W-1:0] quo_in,
	input  wire logic [metsub_pkg::UNIT_W-1:0] rem_in,
	input  wire logic [metsub_pkg::UNIT_W-1:0] unit,
	output logic [metsub_pkg::TICK_W-1:0]      quo_out,
	output logic [metsub_pkg::UNIT_W-1:0]      rem_out
);

	logic [metsub_pkg::UNIT_W-1:0] half;
	logic                          upper;

	always_comb begin
		half    = {1'b0, unit[metsub_pkg::UNIT_W-1:1]};
		upper   = (rem_in >= half);
		quo_out = {quo_in[metsub_pkg::TICK_W-2:0], upper};
		rem_out = upper ? (rem_in - half) : rem_in;
	end

endmodule

`default_nettype wire

// ===== hdl/metric_subdivision_level.sv =====
// ============================================================================
// metric_subdivision_level - metric subdivision level of a tick or tick range
// Finds the first halving level of the denominator unit that fits the request.
// ============================================================================
//
// Channel   Signals                                   Direction  Handshake
// --------  ----------------------------------------  ---------  -------------------------
// config    psel penable pwrite paddr pwdata prdata   in/out     APB write in access phase
// command   start operation tick_start tick_end       in         start high, busy low
// result    valid level found_tick max_level          out        valid for one cycle
//
// The shared divider runs once for the unit length, once for the tick start and, in
// range mode, once for the range end. After the divisions each level takes one step
// of compare and subtract; at most seven halving levels are walked. Reset clears
// the sequencer and loads a denominator of 4. Results cannot be stalled; busy stays
// high from the accepting edge until the cycle the result is shown.
//
// The unit length is whole-note ticks over the denominator (zero counts as one, a
// zero unit counts as one). Halving an even unit lets each quotient double plus one
// bit and each remainder fold down, so no division is repeated per level. The last
// grid tick below the range end is (end - 1) minus its remainder by the unit.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module metric_subdivision_level (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// Configuration port
	input  wire logic                                psel,
	input  wire logic                                penable,
	input  wire logic                                pwrite,
	input  wire logic [2:0]                          paddr,
	input  wire logic [31:0]                         pwdata,
	output logic [31:0]                              prdata,
	output logic                                     pready,
	// Command channel
	input  wire logic                                start,
	output logic                                     busy,
	input  wire logic                                operation,
	input  wire logic [metsub_pkg::TICK_W-1:0]       tick_start,
	input  wire logic [metsub_pkg::TICK_W-1:0]       tick_end,
	// Result channel
	output logic                                     valid,
	output logic signed [metsub_pkg::LEVEL_W-1:0]    level,
	output logic [metsub_pkg::TICK_W-1:0]            found_tick,
	output logic [metsub_pkg::MAXL_W-1:0]            max_level
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_UNIT,
		ST_T1,
		ST_T2,
		ST_LEVEL
	} state_t;

	state_t                              state_q;
	logic [metsub_pkg::DEN_W-1:0]        meter_den_q;
	logic                                op_q;
	logic [metsub_pkg::TICK_W-1:0]       t1_q;
	logic [metsub_pkg::TICK_W-1:0]       t2_q;
	logic [metsub_pkg::UNIT_W-1:0]       unit_q;
	logic [metsub_pkg::TICK_W-1:0]       n_q;
	logic [metsub_pkg::TICK_W-1:0]       m_q;
	logic [metsub_pkg::UNIT_W-1:0]       rn_q;
	logic [metsub_pkg::UNIT_W-1:0]       rm_q;
	logic [metsub_pkg::LVL_W-1:0]        lvl_q;
	logic [metsub_pkg::MAXL_W-1:0]       maxl_q;
	logic                                go_q;
	logic [metsub_pkg::TICK_W-1:0]       dvd_q;
	logic [metsub_pkg::DVS_W-1:0]        dvs_q;
	logic                                valid_q;
	logic [metsub_pkg::LEVEL_W-1:0]      level_q;
	logic [metsub_pkg::TICK_W-1:0]       found_q;

	logic                                div_done;
	logic [metsub_pkg::TICK_W-1:0]       div_quo;
	logic [metsub_pkg::DVS_W-1:0]        div_rem;

	logic [metsub_pkg::TICK_W-1:0]       n_nx;
	logic [metsub_pkg::TICK_W-1:0]       m_nx;
	logic [metsub_pkg::UNIT_W-1:0]       rn_nx;
	logic [metsub_pkg::UNIT_W-1:0]       rm_nx;

	logic                                cfg_wr;
	logic [metsub_pkg::DEN_W-1:0]        den_eff;
	logic [metsub_pkg::UNIT_W-1:0]       unit_div;
	logic                                match;
	logic [metsub_pkg::LVL_W-1:0]        lvl_inc;
	logic [metsub_pkg::LEVEL_W-1:0]      level_pos;
	logic [metsub_pkg::LEVEL_W-1:0]      level_neg;
	logic [metsub_pkg::TICK_W-1:0]       grid_tick;

	// Configuration register; the byte offset within a word is ignored.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[2] == metsub_pkg::REG_METER_DEN);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			meter_den_q <= metsub_pkg::METER_DEN_RESET;
		end else if (cfg_wr) begin
			meter_den_q <= pwdata[metsub_pkg::DEN_W-1:0];
		end
	end

	always_comb begin
		if (paddr[2] == metsub_pkg::REG_METER_DEN) begin
			prdata = {{(32 - metsub_pkg::DEN_W){1'b0}}, meter_den_q};
		end else begin
			prdata = '0;
		end
	end

	// Shared divider and the two halving steps.
	metsub_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.go        (go_q),
		.dividend  (dvd_q),
		.divisor   (dvs_q),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	metsub_halve u_halve_start (
		.quo_in  (n_q),
		.rem_in  (rn_q),
		.unit    (unit_q),
		.quo_out (n_nx),
		.rem_out (rn_nx)
	);

	metsub_halve u_halve_end (
		.quo_in  (m_q),
		.rem_in  (rm_q),
		.unit    (unit_q),
		.quo_out (m_nx),
		.rem_out (rm_nx)
	);

	always_comb begin
		den_eff  = (meter_den_q == '0) ? metsub_pkg::DEN_W'(1) : meter_den_q;
		unit_div = (div_quo[metsub_pkg::UNIT_W-1:0] == '0) ?
			metsub_pkg::UNIT_W'(1) : div_quo[metsub_pkg::UNIT_W-1:0];
		// Range mode matches when a grid point lies strictly above the start and
		// below the end; single-tick mode matches when the unit divides the tick.
		if (op_q) begin
			match = (t2_q > t1_q) && (m_q > n_q);
		end else begin
			match = (rn_q == '0);
		end
		lvl_inc = lvl_q + 1'b1;
		if (32'(lvl_q) > metsub_pkg::LEVEL_MAX) begin
			level_pos = metsub_pkg::LEVEL_W'(metsub_pkg::LEVEL_MAX);
		end else begin
			level_pos = metsub_pkg::LEVEL_W'(lvl_q);
		end
		if (32'(lvl_inc) > metsub_pkg::LEVEL_NEG) begin
			level_neg = metsub_pkg::LEVEL_W'(0) - metsub_pkg::LEVEL_W'(metsub_pkg::LEVEL_NEG);
		end else begin
			level_neg = metsub_pkg::LEVEL_W'(0) - metsub_pkg::LEVEL_W'(lvl_inc);
		end
		grid_tick = t2_q - 1'b1 - {{(metsub_pkg::TICK_W - metsub_pkg::UNIT_W){1'b0}}, rm_q};
	end

	// Sequencer: two divisions on the shared divider, three in range mode, then one level per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q    <= 1'b0;
			t1_q    <= '0;
			t2_q    <= '0;
			unit_q  <= '0;
			n_q     <= '0;
			m_q     <= '0;
			rn_q    <= '0;
			rm_q    <= '0;
			lvl_q   <= '0;
			maxl_q  <= '0;
			go_q    <= 1'b0;
			dvd_q   <= '0;
			dvs_q   <= '0;
			valid_q <= 1'b0;
			level_q <= '0;
			found_q <= '0;
		end else begin
			go_q    <= 1'b0;
			valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						op_q    <= operation;
						t1_q    <= tick_start;
						t2_q    <= tick_end;
						lvl_q   <= '0;
						dvd_q   <= metsub_pkg::TICK_W'(metsub_pkg::WHOLE_TICKS);
						dvs_q   <= metsub_pkg::DVS_W'(den_eff);
						go_q    <= 1'b1;
						state_q <= ST_UNIT;
					end
				end
				ST_UNIT: begin
					if (div_done) begin
						unit_q  <= unit_div;
						maxl_q  <= metsub_pkg::trailing_zeros(unit_div);
						dvd_q   <= t1_q;
						dvs_q   <= metsub_pkg::DVS_W'(unit_div);
						go_q    <= 1'b1;
						state_q <= ST_T1;
					end
				end
				ST_T1: begin
					if (div_done) begin
						n_q  <= div_quo;
						rn_q <= div_rem[metsub_pkg::UNIT_W-1:0];
						if (op_q) begin
							dvd_q   <= t2_q - 1'b1;
							go_q    <= 1'b1;
							state_q <= ST_T2;
						end else begin
							state_q <= ST_LEVEL;
						end
					end
				end
				ST_T2: begin
					if (div_done) begin
						m_q     <= div_quo;
						rm_q    <= div_rem[metsub_pkg::UNIT_W-1:0];
						state_q <= ST_LEVEL;
					end
				end
				ST_LEVEL: begin
					if (match) begin
						valid_q <= 1'b1;
						level_q <= level_pos;
						found_q <= op_q ? grid_tick : '0;
						state_q <= ST_IDLE;
					end else if (unit_q[0]) begin
						// An odd unit cannot be halved exactly: report minus the next level.
						valid_q <= 1'b1;
						level_q <= level_neg;
						found_q <= '0;
						state_q <= ST_IDLE;
					end else begin
						lvl_q  <= lvl_inc;
						unit_q <= {1'b0, unit_q[metsub_pkg::UNIT_W-1:1]};
						n_q    <= n_nx;
						rn_q   <= rn_nx;
						m_q    <= m_nx;
						rm_q   <= rm_nx;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy       = (state_q != ST_IDLE);
	assign valid      = valid_q;
	assign level      = level_q;
	assign found_tick = found_q;
	assign max_level  = maxl_q;

endmodule

`default_nettype wire

// ===== tb/sv/metsub_tb_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// metsub_tb_pkg - shared codes for the subdivision level testbench
// Operation codes of the command channel and the register map of the
// configuration port, used by both the stimulus and the checker.
// ============================================================================

package metsub_tb_pkg;

	// Operation field of a command item.
	typedef enum logic {
		OP_TICK_LEVEL  = 1'b0,
		OP_RANGE_LEVEL = 1'b1
	} op_t;

	// Byte address of the meter denominator register.
	localparam logic [2:0] ADDR_METER_DEN = 3'(4 * metsub_pkg::REG_METER_DEN);

endpackage

// ===== tb/sv/metsub_checker.sv =====
`timescale 1ns / 1ps
// ============================================================================
// metsub_checker - result predictor and scoreboard for the subdivision block
// Follows register writes and accepted commands, predicts each result and
// compares it field by field with what the block shows on the result channel.
// ============================================================================

module metsub_checker
	import metsub_pkg::*;
	import metsub_tb_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [2:0]                paddr,
	input  logic [31:0]               pwdata,
	input  logic                      pready,
	input  logic                      start,
	input  logic                      busy,
	input  logic                      operation,
	input  logic [TICK_W-1:0]         tick_start,
	input  logic [TICK_W-1:0]         tick_end,
	input  logic                      valid,
	input  logic signed [LEVEL_W-1:0] level,
	input  logic [TICK_W-1:0]         found_tick,
	input  logic [MAXL_W-1:0]         max_level,
	output int                        errors,
	output int                        pending,
	output int                        checked
);

	typedef struct packed {
		logic signed [LEVEL_W-1:0] level;
		logic [TICK_W-1:0]         found_tick;
		logic [MAXL_W-1:0]         max_level;
	} subdiv_result_t;

	subdiv_result_t   expected_levels[$];
	subdiv_result_t   want;
	logic [DEN_W-1:0] meter_den;
	int               n_errors;
	int               n_checked;

	// Walks the halving levels of the denominator unit for one command.
	function automatic subdiv_result_t predict_subdivision(input op_t op,
			input logic [TICK_W-1:0] t_lo, input logic [TICK_W-1:0] t_hi,
			input logic [DEN_W-1:0] den);
		subdiv_result_t r;
		int unsigned    unit;
		int unsigned    v;
		int unsigned    halvings;
		int unsigned    lo_q;
		int unsigned    hi_q;
		int unsigned    grid;
		int             lvl;
		unit = WHOLE_TICKS / ((den == 0) ? 1 : 32'(den));
		if (unit == 0) begin
			unit = 1;
		end
		halvings = 0;
		for (v = unit; (v & 1) == 0; v = v >> 1) begin
			halvings++;
		end
		grid = 0;
		lvl = 0;
		if (op == OP_TICK_LEVEL) begin
			while ((32'(t_lo) % unit) != 0) begin
				lvl++;
				if ((unit & 1) != 0) begin
					lvl = -lvl;
					break;
				end
				unit = unit >> 1;
			end
		end else begin
			forever begin
				// A grid point strictly above the start and below the end.
				if (t_hi > t_lo) begin
					lo_q = 32'(t_lo) / unit;
					hi_q = (32'(t_hi) - 1) / unit;
					if (hi_q > lo_q) begin
						grid = hi_q * unit;
						break;
					end
				end
				lvl++;
				if ((unit & 1) != 0) begin
					lvl = -lvl;
					break;
				end
				unit = unit >> 1;
			end
		end
		if (lvl > LEVEL_MAX) begin
			lvl = LEVEL_MAX;
		end
		if (lvl < -LEVEL_NEG) begin
			lvl = -LEVEL_NEG;
		end
		r.level = LEVEL_W'(lvl);
		r.found_tick = TICK_W'(grid);
		r.max_level = (halvings > MAXL_MAX) ? MAXL_W'(MAXL_MAX) : MAXL_W'(halvings);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			meter_den = METER_DEN_RESET;
			expected_levels.delete();
			n_errors = 0;
			n_checked = 0;
			errors <= 0;
			pending <= 0;
			checked <= 0;
		end else begin
			// The result belongs to an older item than one accepted at this edge.
			if (valid === 1'b1) begin
				if (expected_levels.size() == 0) begin
					n_errors++;
					if (n_errors <= 10) begin
						$display("metsub_checker: result with none expected: level %0d tick %0h max %0d",
							level, found_tick, max_level);
					end
				end else begin
					want = expected_levels.pop_front();
					n_checked++;
					if (level !== want.level || found_tick !== want.found_tick
							|| max_level !== want.max_level) begin
						n_errors++;
						if (n_errors <= 10) begin
							$display("metsub_checker: result %0d: level %0d/%0d found_tick %0h/%0h max_level %0d/%0d (expected/actual)",
								n_checked, want.level, level, want.found_tick, found_tick,
								want.max_level, max_level);
						end
					end
				end
			end
			if (psel && penable && pwrite && pready && paddr == ADDR_METER_DEN) begin
				meter_den = pwdata[DEN_W-1:0];
			end
			if (start && !busy) begin
				expected_levels.push_back(predict_subdivision(op_t'(operation), tick_start,
					tick_end, meter_den));
			end
			errors <= n_errors;
			pending <= expected_levels.size();
			checked <= n_checked;
		end
	end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb - testbench top for metric_subdivision_level
// Drives register writes and command items into the block, with random gaps
// and several meter denominators, and leaves all checking to metsub_checker.
// ============================================================================

module tb;
	import metsub_pkg::*;
	import metsub_tb_pkg::*;

	// The run is cut off here; a correct run ends well before it.
	localparam int CYCLE_LIMIT     = 1500000;
	localparam int ITEMS_PER_PHASE = 133;
	// Cycles to wait after the last result.
	localparam int TAIL_CYCLES     = 120;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      psel = 1'b0;
	logic                      penable = 1'b0;
	logic                      pwrite = 1'b0;
	logic [2:0]                paddr = '0;
	logic [31:0]               pwdata = '0;
	logic [31:0]               prdata;
	logic                      pready;
	logic                      start = 1'b0;
	logic                      busy;
	logic                      operation = 1'b0;
	logic [TICK_W-1:0]         tick_start = '0;
	logic [TICK_W-1:0]         tick_end = '0;
	logic                      valid;
	logic signed [LEVEL_W-1:0] level;
	logic [TICK_W-1:0]         found_tick;
	logic [MAXL_W-1:0]         max_level;

	int errors;
	int pending;
	int checked;
	int cycles = 0;
	int n_single = 0;
	int n_range = 0;
	int n_settings = 1;
	// The denominator last written, used only to shape the tick values.
	logic [DEN_W-1:0] den_now = METER_DEN_RESET;

	// Denominators for the random phases, the register extremes among them.
	int den_plan[14] = '{1, 64, 0, 127, 3, 8, 2, 16, 12, 32, 5, 7, 100, 4};

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	metric_subdivision_level dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.start      (start),
		.busy       (busy),
		.operation  (operation),
		.tick_start (tick_start),
		.tick_end   (tick_end),
		.valid      (valid),
		.level      (level),
		.found_tick (found_tick),
		.max_level  (max_level)
	);

	metsub_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.pready     (pready),
		.start      (start),
		.busy       (busy),
		.operation  (operation),
		.tick_start (tick_start),
		.tick_end   (tick_end),
		.valid      (valid),
		.level      (level),
		.found_tick (found_tick),
		.max_level  (max_level),
		.errors     (errors),
		.pending    (pending),
		.checked    (checked)
	);

	// Watchdog: a hung handshake or a lost result ends the run here.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("tb: FAIL");
			$finish;
		end
	end

	// Gap before the next item: mostly none or short, now and then long
	// enough to let the block finish and sit idle for a while.
	function automatic int pick_gap(input bit no_idle);
		int r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 55) begin
			return 0;
		end else if (r < 88) begin
			return $urandom_range(1, 4);
		end else if (r < 97) begin
			return $urandom_range(5, 20);
		end
		return $urandom_range(40, 150);
	endfunction

	// Presents one command and holds it until the block takes it. With a
	// zero gap start stays high, so the next item follows back to back.
	task automatic issue_command(input op_t op, input logic [TICK_W-1:0] t_lo,
			input logic [TICK_W-1:0] t_hi, input int gap);
		operation <= op;
		tick_start <= t_lo;
		tick_end <= t_hi;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		if (op == OP_TICK_LEVEL) begin
			n_single++;
		end else begin
			n_range++;
		end
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Stops sending and waits until every expected result has come back.
	// The checker registers its count, hence the first wait.
	task automatic drain_results();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0) begin
			@(posedge clk);
		end
	endtask

	// Register write: a setup phase, then an access phase that completes at
	// the edge where pready is seen high. Upper data bits carry noise.
	task automatic write_meter_den(input logic [DEN_W-1:0] den);
		drain_results();
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= ADDR_METER_DEN;
		pwdata <= ($urandom() & ~32'h7F) | 32'(den);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		den_now = den;
		n_settings++;
	endtask

	// Random command shaped around the current unit length: most ticks sit
	// near the grid so that the level walk goes deep, and most ranges are a
	// unit or two wide. The rest is full-width noise, empty and inverted ranges.
	task automatic issue_random(input bit no_idle);
		int unsigned unit;
		int unsigned t_lo;
		int unsigned t_hi;
		int unsigned pick;
		op_t         op;
		unit = WHOLE_TICKS / ((den_now == 0) ? 1 : 32'(den_now));
		if (unit == 0) begin
			unit = 1;
		end
		op = op_t'($urandom_range(0, 1));
		pick = $urandom_range(0, 9);
		if (pick < 4) begin
			t_lo = $urandom_range(0, 4 * unit);
		end else if (pick < 6) begin
			t_lo = $urandom_range(0, 4095) * (unit >> $urandom_range(0, 8));
		end else if (pick < 9) begin
			t_lo = $urandom() & 32'hFFFFFF;
		end else begin
			t_lo = 32'hFFFFFF - $urandom_range(0, 2);
		end
		pick = $urandom_range(0, 9);
		if (pick < 6) begin
			t_hi = t_lo + $urandom_range(1, 2 * unit);
		end else if (pick < 8) begin
			t_hi = $urandom() & 32'hFFFFFF;
		end else if (pick < 9) begin
			t_hi = t_lo;
		end else begin
			t_hi = (t_lo > 64) ? t_lo - $urandom_range(1, 64) : 0;
		end
		if (t_hi > 32'hFFFFFF) begin
			t_hi = 32'hFFFFFF;
		end
		issue_command(op, TICK_W'(t_lo), TICK_W'(t_hi), pick_gap(no_idle));
	endtask

	initial begin
		bit no_idle;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed items at the reset denominator, where the unit is 480 ticks
		// (five exact halvings down to an odd unit of 15).
		issue_command(OP_TICK_LEVEL, 24'd0, 24'hFFFFFF, 0);       // downbeat
		issue_command(OP_TICK_LEVEL, 24'd480, 24'd0, 0);          // on the unit
		issue_command(OP_TICK_LEVEL, 24'd240, 24'h555555, 0);     // one halving
		issue_command(OP_TICK_LEVEL, 24'd30, 24'hAAAAAA, 1);
		issue_command(OP_TICK_LEVEL, 24'd15, 24'd0, 0);           // odd unit reached
		issue_command(OP_TICK_LEVEL, 24'd5, 24'd0, 0);            // odd unit misses
		issue_command(OP_TICK_LEVEL, 24'd1, 24'd0, 3);
		issue_command(OP_TICK_LEVEL, 24'hFFFFFF, 24'd0, 0);       // largest tick
		issue_command(OP_TICK_LEVEL, 24'hFFFFF0, 24'd0, 0);
		issue_command(OP_RANGE_LEVEL, 24'd0, 24'd481, 0);         // unit grid inside
		issue_command(OP_RANGE_LEVEL, 24'd0, 24'd480, 0);         // end is exclusive
		issue_command(OP_RANGE_LEVEL, 24'd479, 24'd481, 0);
		issue_command(OP_RANGE_LEVEL, 24'd480, 24'd481, 2);       // start is a grid point
		issue_command(OP_RANGE_LEVEL, 24'd1, 24'd16, 0);
		issue_command(OP_RANGE_LEVEL, 24'd0, 24'd1, 0);           // too narrow at all levels
		issue_command(OP_RANGE_LEVEL, 24'd100, 24'd100, 0);       // empty range
		issue_command(OP_RANGE_LEVEL, 24'd200, 24'd100, 0);       // inverted range
		issue_command(OP_RANGE_LEVEL, 24'hFFFFFF, 24'd0, 0);
		issue_command(OP_RANGE_LEVEL, 24'd0, 24'hFFFFFF, 0);      // widest range
		issue_command(OP_RANGE_LEVEL, 24'hFFFFFE, 24'hFFFFFF, 0);
		issue_command(OP_RANGE_LEVEL, 24'hFFFF00, 24'hFFFFFF, 5);
		drain_results();

		// Random phases: the reset denominator first, then each planned value.
		// Every phase starts only once the block has drained, and a few phases
		// run back to back with no gaps at all.
		for (int phase = 0; phase <= $size(den_plan); phase++) begin
			if (phase > 0) begin
				write_meter_den(DEN_W'(den_plan[phase - 1]));
			end
			no_idle = ($urandom_range(0, 3) == 0);
			for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
				issue_random(no_idle);
				// Now and then the sender waits for the block to empty out.
				if ($urandom_range(0, 49) == 0) begin
					drain_results();
				end
			end
		end

		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("tb: %0d items sent (%0d single-tick, %0d range), %0d results compared",
			n_single + n_range, n_single, n_range, checked);
		$display("tb: %0d meter denominator settings, including 0, 1, 64 and 127",
			n_settings);
		if (errors == 0) begin
			$display("tb: PASS");
		end else begin
			$display("tb: FAIL");
		end
		$finish;
	end

endmodule
